// File: rtl/core/bphcd_pkg.sv
// shared types, codes and the crc16 byte update for the packet header deframer
package bphcd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_B1,
        PH_B2,
        PH_SRC_HI,
        PH_SRC_LO,
        PH_DST_HI,
        PH_DST_LO,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    localparam logic [7:0] CFG_PROTOCOL_ID = 8'd0;
    localparam logic [7:0] CFG_ID_MASK     = 8'd1;
    localparam logic [7:0] CFG_MAX_VERSION = 8'd2;
    localparam logic [7:0] CFG_MIN_SIZE    = 8'd3;

    localparam logic [7:0]  RST_PROTOCOL_ID = 8'h00;
    localparam logic [7:0]  RST_ID_MASK     = 8'h77;
    localparam logic [1:0]  RST_MAX_VERSION = 2'd3;
    localparam logic [7:0]  RST_MIN_SIZE    = 8'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  CRC_LEN  = 8'd2;

    typedef struct packed {
        logic [7:0] protocol_id;
        logic [7:0] id_mask;
        logic [1:0] max_version;
        logic [7:0] min_size;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        priority_res;
        logic        has_destination;
        logic        has_segment;
        logic [1:0]  version;
        logic [2:0]  crypt;
        logic [15:0] source_address;
        logic [15:0] destination_address;
        logic [7:0]  body_length;
    } result_t;

    // reflected crc16 update, one byte unrolled over eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/bus_packet_header_crc_deframer_unit.sv
// top level of the packet header deframer with crc16 check
//
// s_* carries one stream byte per transfer; m_* carries one result per packet
// end or per rejected header. cfg_* writes the four control registers by index
// (0 protocol id, 1 id mask, 2 max version, 3 min size); other indexes are
// dropped. cfg_ready is always high; write only while no packet is in flight.
// A byte goes into an input register, is parsed once the output register can
// take a result, and any result lands in the output register, which drives
// m_valid. Throughput is one byte per cycle while the output register is not
// held full with m_ready low; the parser's unrolled crc update is combinational.
// The input register keeps taking bytes while a result waits in the output
// register; only when the output register is full, not taken, and a byte is
// waiting does s_ready drop. Payload bytes are not forwarded.
// Synchronous active-low reset returns the parser to hunting for byte zero,
// empties both registers and loads the register defaults.
module bus_packet_header_crc_deframer_unit
    import bphcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_priority_res,
    output logic        m_has_destination,
    output logic        m_has_segment,
    output logic [1:0]  m_version,
    output logic [2:0]  m_crypt,
    output logic [15:0] m_source_address,
    output logic [15:0] m_destination_address,
    output logic [7:0]  m_body_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_id <= RST_PROTOCOL_ID;
            cfg_reg.id_mask     <= RST_ID_MASK;
            cfg_reg.max_version <= RST_MAX_VERSION;
            cfg_reg.min_size    <= RST_MIN_SIZE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROTOCOL_ID: cfg_reg.protocol_id <= cfg_data;
                CFG_ID_MASK:     cfg_reg.id_mask     <= cfg_data;
                CFG_MAX_VERSION: cfg_reg.max_version <= cfg_data[1:0];
                CFG_MIN_SIZE:    cfg_reg.min_size    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    bphcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_status              = out_reg.status;
    assign m_priority_res        = out_reg.priority_res;
    assign m_has_destination     = out_reg.has_destination;
    assign m_has_segment         = out_reg.has_segment;
    assign m_version             = out_reg.version;
    assign m_crypt               = out_reg.crypt;
    assign m_source_address      = out_reg.source_address;
    assign m_destination_address = out_reg.destination_address;
    assign m_body_length         = out_reg.body_length;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !in_valid_reg)
        else $error("registers not empty after reset");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(step) && $past(res_valid))
        else $error("result appeared without a parsed byte");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte lost");

endmodule

// File: rtl/core/bphcd_parser.sv
// header parser, address capture and crc check for one stream byte per cycle with step high
module bphcd_parser
    import bphcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  size_reg, size_next;
    logic        id_bad_reg, id_bad_next;
    logic        prio_reg, prio_next;
    logic        dest_reg, dest_next;
    logic        seg_reg, seg_next;
    logic [1:0]  version_reg, version_next;
    logic [2:0]  crypt_reg, crypt_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [15:0] crc_reg, crc_next;

    logic [15:0] crc_upd;
    logic        hdr_bad;
    logic        body_last;

    assign crc_upd   = crc_byte(crc_reg, data_byte);
    assign hdr_bad   = id_bad_reg || (version_reg > cfg.max_version) ||
                       (data_byte < cfg.min_size) || (data_byte < CRC_LEN);
    assign body_last = (count_reg == 8'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            size_reg    <= '0;
            id_bad_reg  <= 1'b0;
            prio_reg    <= 1'b0;
            dest_reg    <= 1'b0;
            seg_reg     <= 1'b0;
            version_reg <= '0;
            crypt_reg   <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            crc_reg     <= CRC_INIT;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            size_reg    <= size_next;
            id_bad_reg  <= id_bad_next;
            prio_reg    <= prio_next;
            dest_reg    <= dest_next;
            seg_reg     <= seg_next;
            version_reg <= version_next;
            crypt_reg   <= crypt_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            crc_reg     <= crc_next;
        end
    end

    // next state and field capture
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        size_next    = size_reg;
        id_bad_next  = id_bad_reg;
        prio_next    = prio_reg;
        dest_next    = dest_reg;
        seg_next     = seg_reg;
        version_next = version_reg;
        crypt_next   = crypt_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        crc_next     = crc_reg;
        if (step) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    prio_next   = data_byte[7];
                    dest_next   = data_byte[3];
                    id_bad_next = ((data_byte & cfg.id_mask) != cfg.protocol_id);
                    src_next    = '0;
                    dst_next    = '0;
                    size_next   = '0;
                    phase_next  = PH_B1;
                end
                PH_B1: begin
                    seg_next     = data_byte[6];
                    version_next = data_byte[4:3];
                    crypt_next   = data_byte[2:0];
                    phase_next   = PH_B2;
                end
                PH_B2: begin
                    size_next = data_byte;
                    if (hdr_bad) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = seg_reg ? PH_SRC_HI : PH_SRC_LO;
                    end
                end
                PH_SRC_HI: begin
                    src_next   = {data_byte, 8'h00};
                    phase_next = PH_SRC_LO;
                end
                PH_SRC_LO: begin
                    src_next = {src_reg[15:8], data_byte};
                    if (dest_reg) begin
                        phase_next = seg_reg ? PH_DST_HI : PH_DST_LO;
                    end else begin
                        crc_next   = CRC_INIT;
                        count_next = size_reg;
                        phase_next = PH_BODY;
                    end
                end
                PH_DST_HI: begin
                    dst_next   = {data_byte, 8'h00};
                    phase_next = PH_DST_LO;
                end
                PH_DST_LO: begin
                    dst_next   = {dst_reg[15:8], data_byte};
                    crc_next   = CRC_INIT;
                    count_next = size_reg;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    count_next = count_reg - 8'd1;
                    if (body_last) begin
                        crc_next   = CRC_INIT;
                        phase_next = PH_HUNT;
                    end else begin
                        crc_next = crc_upd;
                    end
                end
            endcase
        end
    end

    // result for a rejected header or a finished container
    always_comb begin
        res_valid = step && (((phase_reg == PH_B2) && hdr_bad) ||
                             ((phase_reg == PH_BODY) && body_last));
        res.priority_res    = prio_reg;
        res.has_destination = dest_reg;
        res.has_segment     = seg_reg;
        res.version         = version_reg;
        res.crypt           = crypt_reg;
        if (phase_reg == PH_BODY) begin
            res.status              = (crc_upd == 16'h0000) ? ST_OK : ST_CRC_ERR;
            res.source_address      = src_reg;
            res.destination_address = dest_reg ? dst_reg : 16'h0000;
            res.body_length         = size_reg - CRC_LEN;
        end else begin
            res.status              = ST_REJECT;
            res.source_address      = '0;
            res.destination_address = '0;
            res.body_length         = '0;
        end
    end

    a_body_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> count_reg != 8'd0)
        else $error("body phase with zero byte count");

    a_reject_from_b2: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_REJECT |-> phase_reg == PH_B2)
        else $error("reject result outside header size byte");

    a_body_end_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && phase_reg == PH_BODY |=> phase_reg == PH_HUNT && crc_reg == CRC_INIT)
        else $error("container end did not restart hunting");

endmodule

// File: bench/packet_result_checker.sv
`timescale 1ns / 100ps
// result checker for the packet deframer: predicts results from accepted bytes and compares them
module packet_result_checker
    import bphcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic        m_priority_res,
    input  logic        m_has_destination,
    input  logic        m_has_segment,
    input  logic [1:0]  m_version,
    input  logic [2:0]  m_crypt,
    input  logic [15:0] m_source_address,
    input  logic [15:0] m_destination_address,
    input  logic [7:0]  m_body_length,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    cfg_t        regs;
    phase_t      stage;
    logic        id_miss;
    logic        prio;
    logic        dest;
    logic        seg;
    logic [1:0]  ver;
    logic [2:0]  crypt;
    logic [7:0]  csize;
    logic [7:0]  body_left;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [15:0] crc;
    result_t     due_results[$];
    result_t     want;

    assign pending = due_results.size();

    // reflected crc16, one input bit folded in per step
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic result_t packet_result(input status_t st, input logic [15:0] src,
                                              input logic [15:0] dst, input logic [7:0] len);
        result_t r;
        r.status              = st;
        r.priority_res        = prio;
        r.has_destination     = dest;
        r.has_segment         = seg;
        r.version             = ver;
        r.crypt               = crypt;
        r.source_address      = src;
        r.destination_address = dst;
        r.body_length         = len;
        return r;
    endfunction

    task automatic open_container();
        crc       = CRC_INIT;
        body_left = csize;
        stage     = PH_BODY;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic bad;
        case (stage)
            PH_HUNT: begin
                prio     = b[7];
                dest     = b[3];
                seg      = 1'b0;
                ver      = 2'd0;
                crypt    = 3'd0;
                id_miss  = (b & regs.id_mask) != regs.protocol_id;
                src_addr = '0;
                dst_addr = '0;
                csize    = '0;
                stage    = PH_B1;
            end
            PH_B1: begin
                seg   = b[6];
                ver   = b[4:3];
                crypt = b[2:0];
                stage = PH_B2;
            end
            PH_B2: begin
                // id, version and size are all judged on the size byte
                bad   = id_miss || ver > regs.max_version || b < regs.min_size || b < CRC_LEN;
                csize = b;
                if (bad) begin
                    due_results.push_back(packet_result(ST_REJECT, '0, '0, '0));
                    id_miss = 1'b0;
                    stage   = PH_HUNT;
                end else begin
                    stage = seg ? PH_SRC_HI : PH_SRC_LO;
                end
            end
            PH_SRC_HI: begin
                src_addr = {b, 8'h00};
                stage    = PH_SRC_LO;
            end
            PH_SRC_LO: begin
                src_addr[7:0] = b;
                if (dest) begin
                    stage = seg ? PH_DST_HI : PH_DST_LO;
                end else begin
                    open_container();
                end
            end
            PH_DST_HI: begin
                dst_addr = {b, 8'h00};
                stage    = PH_DST_LO;
            end
            PH_DST_LO: begin
                dst_addr[7:0] = b;
                open_container();
            end
            default: begin
                crc = crc_fold(crc, b);
                if (body_left != 0) begin
                    body_left--;
                end
                if (body_left == 0) begin
                    due_results.push_back(packet_result(crc == 16'h0000 ? ST_OK : ST_CRC_ERR,
                                                        src_addr, dest ? dst_addr : 16'h0000,
                                                        csize - CRC_LEN));
                    crc   = CRC_INIT;
                    stage = PH_HUNT;
                end
            end
        endcase
    endtask

    task automatic note_failure(input string what, input logic [15:0] exp_val,
                                input logic [15:0] got_val);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            note_failure(what, exp_val, got_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.protocol_id = RST_PROTOCOL_ID;
            regs.id_mask     = RST_ID_MASK;
            regs.max_version = RST_MAX_VERSION;
            regs.min_size    = RST_MIN_SIZE;
            stage     = PH_HUNT;
            id_miss   = 1'b0;
            prio      = 1'b0;
            dest      = 1'b0;
            seg       = 1'b0;
            ver       = 2'd0;
            crypt     = 3'd0;
            csize     = '0;
            body_left = '0;
            src_addr  = '0;
            dst_addr  = '0;
            crc       = CRC_INIT;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PROTOCOL_ID: regs.protocol_id = cfg_data;
                    CFG_ID_MASK:     regs.id_mask     = cfg_data;
                    CFG_MAX_VERSION: regs.max_version = cfg_data[1:0];
                    CFG_MIN_SIZE:    regs.min_size    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    note_failure("result transfer with nothing outstanding", 16'h0000,
                                 m_source_address);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("priority_res", 16'(want.priority_res),
                                16'(m_priority_res));
                    check_field("has_destination", 16'(want.has_destination),
                                16'(m_has_destination));
                    check_field("has_segment", 16'(want.has_segment),
                                16'(m_has_segment));
                    check_field("version", 16'(want.version), 16'(m_version));
                    check_field("crypt", 16'(want.crypt), 16'(m_crypt));
                    check_field("source_address", want.source_address, m_source_address);
                    check_field("destination_address", want.destination_address,
                                m_destination_address);
                    check_field("body_length", 16'(want.body_length),
                                16'(m_body_length));
                end
            end
        end
    end

endmodule

// File: bench/tb_bus_packet_header_crc_deframer_unit.sv
`timescale 1ns / 100ps
// testbench top for the packet deframer: clock, reset, byte stream stimulus and verdict
module tb_bus_packet_header_crc_deframer_unit;
    import bphcd_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_ID,
        FLAW_VERSION,
        FLAW_SIZE
    } flaw_t;

    localparam logic [7:0] CFG_UNUSED_IDX = 8'hFF;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         DRAIN_LIMIT    = 50000;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_status;
    logic        m_priority_res;
    logic        m_has_destination;
    logic        m_has_segment;
    logic [1:0]  m_version;
    logic [2:0]  m_crypt;
    logic [15:0] m_source_address;
    logic [15:0] m_destination_address;
    logic [7:0]  m_body_length;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index   = 8'h00;
    logic [7:0]  cfg_data    = 8'h00;
    int          fail_count;
    int          pending;

    int          src_idle   = 0;
    int          snk_stall  = 0;
    int          bytes_sent = 0;
    // settings the packet generator builds against
    logic [7:0]  gen_pid    = RST_PROTOCOL_ID;
    logic [7:0]  gen_mask   = RST_ID_MASK;
    logic [1:0]  gen_maxver = RST_MAX_VERSION;
    logic [7:0]  gen_min    = RST_MIN_SIZE;

    bus_packet_header_crc_deframer_unit dut (.*);
    packet_result_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_bus_packet_header_crc_deframer_unit NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall);
    end

    function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [7:0] pid, input logic [7:0] mask,
                               input logic [1:0] maxver, input logic [7:0] min_sz);
        logic [5:0] junk;
        junk = 6'($urandom_range(63));
        write_reg(CFG_PROTOCOL_ID, pid);
        write_reg(CFG_ID_MASK, mask);
        // bits above the version width are dropped by the block
        write_reg(CFG_MAX_VERSION, {junk, maxver});
        write_reg(CFG_MIN_SIZE, min_sz);
        write_reg(CFG_UNUSED_IDX, 8'($urandom_range(255)));
        cfg_valid  <= 1'b0;
        gen_pid    = pid;
        gen_mask   = mask;
        gen_maxver = maxver;
        gen_min    = min_sz;
    endtask

    // stop sending, let every outstanding result out, then let the parser settle
    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_packet(input flaw_t flaw_in);
        flaw_t       flaw;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  bit_sel;
        logic [7:0]  d;
        logic [1:0]  ver;
        logic [15:0] crc;
        int          size;
        int          hi;
        flaw = flaw_in;
        if ((flaw == FLAW_ID && gen_mask == 8'h00) ||
            (flaw == FLAW_VERSION && gen_maxver == 2'd3)) begin
            flaw = FLAW_SIZE;
        end
        b0  = (8'($urandom_range(255)) & ~gen_mask) | (gen_pid & gen_mask);
        ver = 2'($urandom_range(gen_maxver));
        if (flaw == FLAW_ID) begin
            do bit_sel = 8'h01 << $urandom_range(7); while ((bit_sel & gen_mask) == 8'h00);
            b0 = b0 ^ bit_sel;
        end
        if (flaw == FLAW_VERSION) begin
            ver = 2'($urandom_range(3, gen_maxver + 1));
        end
        hi = (gen_min > 245) ? 255 : gen_min + 10;
        if (flaw == FLAW_SIZE) begin
            size = $urandom_range(gen_min - 1, 0);
        end else if ($urandom_range(39) == 0) begin
            size = $urandom_range(255, gen_min);
        end else begin
            size = $urandom_range(hi, gen_min);
        end
        b1      = 8'($urandom_range(255));
        b1[4:3] = ver;
        push_byte(b0);
        push_byte(b1);
        push_byte(size[7:0]);
        if (flaw != FLAW_NONE) begin
            return;
        end
        if (b1[6]) begin
            push_byte(8'($urandom_range(255)));
        end
        push_byte(8'($urandom_range(255)));
        if (b0[3]) begin
            if (b1[6]) begin
                push_byte(8'($urandom_range(255)));
            end
            push_byte(8'($urandom_range(255)));
        end
        crc = CRC_INIT;
        for (int i = 0; i < size - 2; i++) begin
            d   = 8'($urandom_range(255));
            crc = modbus_crc_next(crc, d);
            push_byte(d);
        end
        // a fifth of the packets carry a damaged crc
        if ($urandom_range(4) == 0) begin
            crc = crc ^ 16'($urandom_range(65535, 1));
        end
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
    endtask

    task automatic send_unit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            send_packet(FLAW_NONE);
        end else if (pick < 90) begin
            send_packet(flaw_t'($urandom_range(3, 1)));
        end else begin
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int src, input int snk, input int budget);
        int target;
        src_idle  = src;
        snk_stall = snk;
        target    = bytes_sent + budget;
        while (bytes_sent < target) begin
            send_unit();
        end
    endtask

    initial begin
        logic [7:0]  script[$];
        logic [15:0] crc;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        script = '{
            // header rejected on a protocol id mismatch
            8'h01, 8'h00, 8'h05,
            // smallest container, crc only, priority set and crypt all ones
            8'h80, 8'h07, 8'h02, 8'hFF, 8'hFF, 8'hFF,
            // container sizes one and zero cannot hold the crc
            8'h00, 8'h00, 8'h01,
            8'h00, 8'h00, 8'h00,
            // segmented source and destination, version three, one body byte
            8'h08, 8'h5F, 8'h03, 8'hAB, 8'hCD, 8'h12, 8'h34, 8'h5A
        };
        foreach (script[i]) begin
            push_byte(script[i]);
        end
        // crc of that body with its low byte inverted
        crc = modbus_crc_next(CRC_INIT, 8'h5A);
        push_byte(~crc[7:0]);
        push_byte(crc[15:8]);

        run_phase(0, 0, 100);
        drain();
        load_config(8'hFF, 8'hFF, 2'd0, 8'd2);
        run_phase(82, 0, 80);
        drain();
        load_config(8'h12, 8'h3F, 2'd1, 8'd9);
        run_phase(0, 82, 80);
        drain();
        // every good packet here is a full-size container
        load_config(8'h00, 8'h00, 2'd2, 8'd255);
        run_phase(38, 38, 150);
        drain();
        load_config(8'h70, 8'hF0, 2'd3, 8'd3);
        run_phase(38, 38, 70);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_bus_packet_header_crc_deframer_unit OK");
        end else begin
            $display("tb_bus_packet_header_crc_deframer_unit NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/bphcd_pkg.sv
rtl/core/bphcd_parser.sv
rtl/core/bus_packet_header_crc_deframer_unit.sv
bench/packet_result_checker.sv
bench/tb_bus_packet_header_crc_deframer_unit.sv
